// ----- rtl/meter_register_poll_sequencer_assert.svh -----
// Assertion macros for the meter register poll sequencer.
`ifndef METER_REGISTER_POLL_SEQUENCER_ASSERT_SVH
`define METER_REGISTER_POLL_SEQUENCER_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define MRPS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mrps assertion failed");

// Check that cons holds in the cycle after ante.
`define MRPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mrps assertion failed");

`endif

// ----- rtl/mrps_pkg.sv -----
package mrps_pkg;

  localparam int DEF_RECORDS_PER_BUFFER = 64;
  localparam int DEF_BUFFER_COUNT       = 3;

  localparam logic [7:0] CMD_READ = 8'h58;

  localparam logic [2:0] PHASE_LAST = 3'd5;
  localparam logic [2:0] PHASE_DONE = 3'd6;

  localparam logic [1:0] ACT_TICK     = 2'd0;
  localparam logic [1:0] ACT_RESPONSE = 2'd1;
  localparam logic [1:0] ACT_RELEASE  = 2'd2;

  typedef enum logic [2:0] {
    ST_NONE      = 3'd0,
    ST_REQUEST   = 3'd1,
    ST_CHECK_ERR = 3'd2,
    ST_RECORD    = 3'd3,
    ST_IGNORED   = 3'd4
  } status_t;

  function automatic logic [7:0] poll_addr(input logic [2:0] phase);
    logic [7:0] addr;
    case (phase)
      3'd0:    addr = 8'h04;
      3'd1:    addr = 8'h06;
      3'd2:    addr = 8'h08;
      3'd3:    addr = 8'h0C;
      3'd4:    addr = 8'h01;
      3'd5:    addr = 8'h03;
      default: addr = 8'h00;
    endcase
    return addr;
  endfunction

endpackage

// ----- rtl/meter_register_poll_sequencer.sv -----
// A result is in the output register in the cycle after its input transfer.
// Throughput: one item per cycle; the single output register accepts a new item
// whenever it is empty or its result is taken in the same cycle.
// Reset (rst_n low, synchronous): sequencer idle, buffer 0 slot 0, all full flags
// and held register values cleared, output register empty.
`include "meter_register_poll_sequencer_assert.svh"

module meter_register_poll_sequencer #(
  parameter int RECORDS_PER_BUFFER = mrps_pkg::DEF_RECORDS_PER_BUFFER,
  parameter int BUFFER_COUNT       = mrps_pkg::DEF_BUFFER_COUNT
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_action,
  input  logic [7:0]         in_rx_data_high,
  input  logic [7:0]         in_rx_data_mid,
  input  logic [7:0]         in_rx_data_low,
  input  logic [7:0]         in_rx_check,
  input  logic [1:0]         in_release_buffer,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_status,
  output logic [7:0]         out_request_address,
  output logic [23:0]        out_current_raw,
  output logic [23:0]        out_voltage_raw,
  output logic signed [23:0] out_power_raw,
  output logic [23:0]        out_phase_raw,
  output logic [23:0]        out_current_wave_raw,
  output logic [23:0]        out_voltage_wave_raw,
  output logic [1:0]         out_buffer_index,
  output logic [5:0]         out_record_slot,
  output logic [2:0]         out_full_mask
);

  localparam int SLOT_W = (RECORDS_PER_BUFFER > 1) ? $clog2(RECORDS_PER_BUFFER) : 1;
  localparam int BUF_W  = $clog2(BUFFER_COUNT);

  logic [2:0]              phase_r, phase_nxt;
  logic [23:0]             held_r [5];
  logic [SLOT_W-1:0]       fill_slot_r, fill_slot_nxt;
  logic [BUF_W-1:0]        fill_buffer_r, fill_buffer_nxt;
  logic [BUFFER_COUNT-1:0] full_flags_r, full_flags_nxt;
  logic                    held_we;

  logic                    out_valid_r;
  mrps_pkg::status_t       status_r, status_nxt;
  logic [7:0]              req_addr_r, req_addr_nxt;
  logic [23:0]             rec_r [6];
  logic [23:0]             rec_nxt [6];
  logic [BUF_W-1:0]        buf_idx_r, buf_idx_nxt;
  logic [SLOT_W-1:0]       slot_r, slot_nxt;

  logic                    in_fire;
  logic                    busy;
  logic [7:0]              cur_addr;
  logic [7:0]              sum;
  logic                    chk_ok;
  logic [23:0]             value;
  logic [BUF_W+1:0]        buf_ext;
  logic [SLOT_W+5:0]       slot_ext;
  logic [BUFFER_COUNT+2:0] flags_ext;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  assign busy     = phase_r < mrps_pkg::PHASE_DONE;
  assign cur_addr = mrps_pkg::poll_addr(phase_r);
  assign sum      = mrps_pkg::CMD_READ + cur_addr + in_rx_data_high + in_rx_data_mid
                    + in_rx_data_low;
  assign chk_ok   = ~sum == in_rx_check;
  assign value    = {in_rx_data_high, in_rx_data_mid, in_rx_data_low};

  always_comb begin
    phase_nxt       = phase_r;
    fill_slot_nxt   = fill_slot_r;
    fill_buffer_nxt = fill_buffer_r;
    full_flags_nxt  = full_flags_r;
    held_we         = 1'b0;
    status_nxt      = mrps_pkg::ST_NONE;
    req_addr_nxt    = 8'h00;
    buf_idx_nxt     = '0;
    slot_nxt        = '0;
    for (int i = 0; i < 6; i++) begin
      rec_nxt[i] = 24'h0;
    end
    case (in_action)
      mrps_pkg::ACT_TICK: begin
        if (!busy) begin
          phase_nxt    = 3'd0;
          status_nxt   = mrps_pkg::ST_REQUEST;
          req_addr_nxt = mrps_pkg::poll_addr(3'd0);
        end
      end
      mrps_pkg::ACT_RESPONSE: begin
        if (!busy) begin
          status_nxt = mrps_pkg::ST_IGNORED;
        end else if (!chk_ok) begin
          phase_nxt  = mrps_pkg::PHASE_DONE;
          status_nxt = mrps_pkg::ST_CHECK_ERR;
        end else if (phase_r != mrps_pkg::PHASE_LAST) begin
          held_we      = 1'b1;
          phase_nxt    = phase_r + 3'd1;
          status_nxt   = mrps_pkg::ST_REQUEST;
          req_addr_nxt = mrps_pkg::poll_addr(phase_r + 3'd1);
        end else begin
          phase_nxt   = mrps_pkg::PHASE_DONE;
          status_nxt  = mrps_pkg::ST_RECORD;
          for (int i = 0; i < 5; i++) begin
            rec_nxt[i] = held_r[i];
          end
          rec_nxt[5]  = value;
          buf_idx_nxt = fill_buffer_r;
          slot_nxt    = fill_slot_r;
          if (fill_slot_r == SLOT_W'(RECORDS_PER_BUFFER - 1)) begin
            fill_slot_nxt                 = '0;
            full_flags_nxt[fill_buffer_r] = 1'b1;
            if (fill_buffer_r == BUF_W'(BUFFER_COUNT - 1)) begin
              fill_buffer_nxt = '0;
            end else begin
              fill_buffer_nxt = fill_buffer_r + BUF_W'(1);
            end
            full_flags_nxt[fill_buffer_nxt] = 1'b0;
          end else begin
            fill_slot_nxt = fill_slot_r + SLOT_W'(1);
          end
        end
      end
      mrps_pkg::ACT_RELEASE: begin
        for (int b = 0; b < BUFFER_COUNT; b++) begin
          if (4'(b) == {2'b00, in_release_buffer}) begin
            full_flags_nxt[b] = 1'b0;
          end
        end
      end
      default: begin
        status_nxt = mrps_pkg::ST_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= mrps_pkg::PHASE_DONE;
      fill_slot_r   <= '0;
      fill_buffer_r <= '0;
      full_flags_r  <= '0;
      out_valid_r   <= 1'b0;
      for (int i = 0; i < 5; i++) begin
        held_r[i] <= 24'h0;
      end
    end else begin
      if (in_fire) begin
        phase_r       <= phase_nxt;
        fill_slot_r   <= fill_slot_nxt;
        fill_buffer_r <= fill_buffer_nxt;
        full_flags_r  <= full_flags_nxt;
        if (held_we) begin
          held_r[phase_r] <= value;
        end
      end
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      status_r   <= status_nxt;
      req_addr_r <= req_addr_nxt;
      rec_r      <= rec_nxt;
      buf_idx_r  <= buf_idx_nxt;
      slot_r     <= slot_nxt;
    end
  end

  assign buf_ext   = {2'b00, buf_idx_r};
  assign slot_ext  = {6'b000000, slot_r};
  assign flags_ext = {3'b000, full_flags_r};

  assign out_valid            = out_valid_r;
  assign out_status           = status_r;
  assign out_request_address  = req_addr_r;
  assign out_current_raw      = rec_r[0];
  assign out_voltage_raw      = rec_r[1];
  assign out_power_raw        = $signed(rec_r[2]);
  assign out_phase_raw        = rec_r[3];
  assign out_current_wave_raw = rec_r[4];
  assign out_voltage_wave_raw = rec_r[5];
  assign out_buffer_index     = buf_ext[1:0];
  assign out_record_slot      = slot_ext[5:0];
  assign out_full_mask        = flags_ext[2:0];

  `MRPS_ASSERT_SAME(a_phase_range, clk, rst_n, 1'b1, phase_r <= mrps_pkg::PHASE_DONE)
  `MRPS_ASSERT_SAME(a_fill_not_full, clk, rst_n, 1'b1, !full_flags_r[fill_buffer_r])
  `MRPS_ASSERT_SAME(a_req_addr, clk, rst_n, out_valid_r && status_r == mrps_pkg::ST_REQUEST,
                    req_addr_r != 8'h00)
  `MRPS_ASSERT_NEXT(a_record_idle, clk, rst_n, in_fire && status_nxt == mrps_pkg::ST_RECORD,
                    !busy)

endmodule
